>>> rtl/pet_pkg.sv
// Shared types and constants for the Prewitt edge threshold block.
package pet_pkg;

    localparam int unsigned WEIGHT_RED   = 19595;
    localparam int unsigned WEIGHT_GREEN = 38470;
    localparam int unsigned WEIGHT_BLUE  = 7471;

    localparam int PROD_W     = 24;
    localparam int SQ_W       = 21;
    localparam int ROOT_W     = 11;
    localparam int SQRT_STEPS = 11;
    localparam int STEP_W     = 4;

    localparam logic [1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_EDGE_THRESHOLD = 2'd2;

    localparam logic [9:0]  RST_FRAME_WIDTH    = 10'd512;
    localparam logic [9:0]  RST_FRAME_HEIGHT   = 10'd512;
    localparam logic [10:0] RST_EDGE_THRESHOLD = 11'd170;
    localparam logic [9:0]  HEIGHT_LIMIT       = 10'd512;

    typedef struct packed {
        logic accept;
        logic ld_prod;
        logic ld_gray;
        logic commit;
        logic ld_grad;
        logic sqrt_init;
        logic sqrt_step;
        logic ld_out;
    } cmd_t;

    typedef struct packed {
        logic produced;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/prewitt_edge_threshold.sv
// Top level: Prewitt edge detector with threshold on an RGB pixel stream.
// A pixel is accepted only in idle. An interior pixel then runs through product, sum,
// commit, gradient, square and an 11-step root, and its result is loaded into the output
// register, later while a previous result is still held. Border pixels give no result.
// Synchronous active-low reset clears control, counters and window; line stores are
// not cleared. Registers reset to width 512, height 512, threshold 170.
module prewitt_edge_threshold #(
    parameter int MAX_WIDTH = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // edge_value [7:0]
    output logic        m_tlast,   // row_done
    output logic        m_tuser,   // frame_done [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    pet_pkg::cmd_t cmd;
    pet_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    pet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pet_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/pet_ctrl.sv
// Sequencing state machine for one pixel transaction.
module pet_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  pet_pkg::sts_t sts,
    output pet_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PROD   = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_GRAD   = 3'd4;
    localparam logic [2:0] ST_SQ     = 3'd5;
    localparam logic [2:0] ST_SQRT   = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0]                   state_reg, state_next;
    logic [pet_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         sqrt_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign sqrt_last = (step_reg == pet_pkg::STEP_W'(pet_pkg::SQRT_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                cmd.ld_prod = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.ld_gray = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = sts.produced ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                cmd.ld_grad = 1'b1;
                state_next  = ST_SQ;
            end
            ST_SQ: begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (sqrt_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PROD))
        else $error("transaction accepted but sequence did not start");
    a_sqrt_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT && sqrt_last) |=> (state_reg == ST_OUT))
        else $error("square root did not finish after its step count");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out |-> sts.out_free)
        else $error("result loaded over a pending transaction");
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT && !sts.produced) |=> s_tready)
        else $error("border pixel did not release the input");
`endif

endmodule

>>> rtl/pet_dp.sv
// Datapath: gray conversion, line stores, window, gradients, root and output stage.
module pet_dp #(
    parameter int MAX_WIDTH = 512
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  pet_pkg::cmd_t cmd,
    output pet_pkg::sts_t sts,
    input  logic [23:0]   s_tdata,
    input  logic          cfg_valid,
    input  logic [1:0]    cfg_index,
    input  logic [10:0]   cfg_data,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic          m_tuser
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = (CW + 1 > 10) ? CW + 1 : 10;

    logic [9:0]  width_cfg_reg, height_cfg_reg;
    logic [10:0] thr_reg;

    logic [7:0] top_mem [MAX_WIDTH];
    logic [7:0] mid_mem [MAX_WIDTH];
    logic [7:0] top_q_reg, mid_q_reg;

    logic [7:0] red_reg, green_reg, blue_reg;
    logic [pet_pkg::PROD_W-1:0] pr_reg, pg_reg, pb_reg, psum;
    logic [7:0] gray_reg;

    logic [7:0] win_reg [3][3];
    logic [CW-1:0] col_reg;
    logic [8:0]    row_reg;
    logic          row_end_reg, frame_end_reg;

    logic [CMP_W-1:0] w_eff, w_cfg_x, col_plus;
    logic [9:0]       h_eff;
    logic             row_end, frame_end;

    logic signed [10:0] gx_reg, gy_reg, gx_next, gy_next;
    logic [pet_pkg::SQ_W-1:0] v_reg, root_reg, bit_reg, trial;
    logic [10:0] mag;
    logic [7:0]  val;

    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_last_reg, m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= pet_pkg::RST_FRAME_WIDTH;
            height_cfg_reg <= pet_pkg::RST_FRAME_HEIGHT;
            thr_reg        <= pet_pkg::RST_EDGE_THRESHOLD;
        end else if (cfg_valid) begin
            case (cfg_index)
                pet_pkg::CFG_FRAME_WIDTH:    width_cfg_reg  <= cfg_data[9:0];
                pet_pkg::CFG_FRAME_HEIGHT:   height_cfg_reg <= cfg_data[9:0];
                pet_pkg::CFG_EDGE_THRESHOLD: thr_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // geometry
    assign w_cfg_x  = CMP_W'(width_cfg_reg);
    assign w_eff    = (w_cfg_x < CMP_W'(3)) ? CMP_W'(3) :
                      (w_cfg_x > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_cfg_x;
    assign h_eff    = (height_cfg_reg < 10'd3) ? 10'd3 :
                      (height_cfg_reg > pet_pkg::HEIGHT_LIMIT) ? pet_pkg::HEIGHT_LIMIT
                                                               : height_cfg_reg;
    assign col_plus  = CMP_W'(col_reg) + CMP_W'(1);
    assign row_end   = (col_plus >= w_eff);
    assign frame_end = row_end && ((10'(row_reg) + 10'd1) >= h_eff);

    // line stores
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            top_q_reg <= top_mem[col_reg];
        end
        if (cmd.commit) begin
            top_mem[col_reg] <= mid_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mid_q_reg <= mid_mem[col_reg];
        end
        if (cmd.commit) begin
            mid_mem[col_reg] <= gray_reg;
        end
    end

    // gray conversion
    assign psum = pr_reg + pg_reg + pb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            red_reg   <= s_tdata[7:0];
            green_reg <= s_tdata[15:8];
            blue_reg  <= s_tdata[23:16];
        end
        if (cmd.ld_prod) begin
            pr_reg <= pet_pkg::PROD_W'(pet_pkg::WEIGHT_RED)   * pet_pkg::PROD_W'(red_reg);
            pg_reg <= pet_pkg::PROD_W'(pet_pkg::WEIGHT_GREEN) * pet_pkg::PROD_W'(green_reg);
            pb_reg <= pet_pkg::PROD_W'(pet_pkg::WEIGHT_BLUE)  * pet_pkg::PROD_W'(blue_reg);
        end
        if (cmd.ld_gray) begin
            gray_reg <= psum[23:16];
        end
    end

    // window and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
            col_reg       <= '0;
            row_reg       <= '0;
            row_end_reg   <= 1'b0;
            frame_end_reg <= 1'b0;
        end else if (cmd.commit) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_q_reg;
            win_reg[1][2] <= mid_q_reg;
            win_reg[2][2] <= gray_reg;
            row_end_reg   <= row_end;
            frame_end_reg <= frame_end;
            if (row_end) begin
                col_reg <= '0;
                row_reg <= frame_end ? 9'd0 : row_reg + 9'd1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    assign sts.produced = (row_reg >= 9'd2) && (col_reg >= CW'(2));

    // gradients
    always_comb begin
        gx_next = '0;
        gy_next = '0;
        for (int i = 0; i < 3; i++) begin
            gx_next = gx_next + $signed({3'b000, win_reg[i][2]})
                              - $signed({3'b000, win_reg[i][0]});
            gy_next = gy_next + $signed({3'b000, win_reg[2][i]})
                              - $signed({3'b000, win_reg[0][i]});
        end
    end

    // square root, one result bit per step
    assign trial = root_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.ld_grad) begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (cmd.sqrt_init) begin
            v_reg    <= pet_pkg::SQ_W'(22'(gx_reg * gx_reg) + 22'(gy_reg * gy_reg));
            root_reg <= '0;
            bit_reg  <= pet_pkg::SQ_W'(1) << (pet_pkg::SQ_W - 1);
        end else if (cmd.sqrt_step) begin
            if (v_reg >= trial) begin
                v_reg    <= v_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign mag = root_reg[pet_pkg::ROOT_W-1:0];
    assign val = (mag > thr_reg) ? 8'd0 :
                 (mag > 11'd127) ? 8'd255 : {mag[6:0], 1'b0};

    // output stage
    assign sts.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.ld_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            m_data_reg <= val;
            m_last_reg <= row_end_reg;
            m_user_reg <= frame_end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> tb/prewitt_edge_threshold_tb.sv
// Testbench for prewitt_edge_threshold: directed and random pixel frames checked against a built-in model.
module prewitt_edge_threshold_tb;

    localparam int MAXW = 512;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       row_done;
        logic       frame_done;
    } edge_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    prewitt_edge_threshold dut (.*);

    // predictor state
    logic [9:0]  pw_width;
    logic [9:0]  pw_height;
    logic [10:0] pw_thresh;
    logic [7:0]  lines [2*MAXW];
    logic [7:0]  win [3][3];
    int unsigned col_cnt, row_cnt;

    pixel_t    pixel_q [$];
    edge_res_t edge_q [$];
    int        fail_cnt = 0;
    int        hold_cycles = 0;
    bit        stall_req = 1'b0;
    bit        stall_taken = 1'b0;
    bit        s_tready_seen = 1'b0;
    int        idle_pct;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned isqrt(int unsigned v);
        int unsigned root, bit_v;
        root = 0;
        bit_v = 1 << 30;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= root + bit_v) begin
                v -= root + bit_v;
                root = (root >> 1) + bit_v;
            end else begin
                root >>= 1;
            end
            bit_v >>= 2;
        end
        return root;
    endfunction

    task automatic predict_edge(input pixel_t px);
        int unsigned w, h, gray, c, mag, val;
        int gx, gy;
        logic [7:0] top, mid;
        bit row_end, frame_end;
        edge_res_t res;
        w = (pw_width < 3) ? 3 : (pw_width > MAXW) ? MAXW : pw_width;
        h = (pw_height < 3) ? 3 : (pw_height > 512) ? 512 : pw_height;
        gray = (pet_pkg::WEIGHT_RED * px.red + pet_pkg::WEIGHT_GREEN * px.green
                + pet_pkg::WEIGHT_BLUE * px.blue) >> 16;
        c = col_cnt % MAXW;
        top = lines[c];
        mid = lines[MAXW + c];
        row_end = (col_cnt + 1 >= w);
        frame_end = row_end && (row_cnt + 1 >= h);
        lines[c] = mid;
        lines[MAXW + c] = gray[7:0];
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = gray[7:0];
        if (row_cnt >= 2 && col_cnt >= 2) begin
            gx = 0;
            gy = 0;
            for (int i = 0; i < 3; i++) begin
                gx += int'(win[i][2]) - int'(win[i][0]);
                gy += int'(win[2][i]) - int'(win[0][i]);
            end
            mag = isqrt(gx * gx + gy * gy);
            if (mag > pw_thresh) val = 0;
            else val = (2 * mag > 255) ? 255 : 2 * mag;
            res.edge_value = val[7:0];
            res.row_done = row_end;
            res.frame_done = frame_end;
            edge_q.push_back(res);
        end
        if (row_end) begin
            col_cnt = 0;
            row_cnt = frame_end ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready_seen) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pixel_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // acceptance sampled at rising edge
    always @(posedge aclk) begin
        s_tready_seen <= 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            s_tready_seen <= 1'b1;
            predict_edge(pixel_t'(s_tdata));
        end
    end

    // receiver and monitor
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_req && !stall_taken) begin
            m_tready    <= 1'b0;
            stall_taken <= 1'b1;
            hold_cycles <= 400;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        edge_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (edge_q.size() == 0) begin
                $error("unexpected result edge_value=%0d", m_tdata);
                fail_cnt++;
            end else begin
                want = edge_q.pop_front();
                if (m_tdata !== want.edge_value) begin
                    $error("edge_value exp %0d got %0d", want.edge_value, m_tdata);
                    fail_cnt++;
                end
                if (m_tlast !== want.row_done) begin
                    $error("row_done exp %0d got %0d", want.row_done, m_tlast);
                    fail_cnt++;
                end
                if (m_tuser !== want.frame_done) begin
                    $error("frame_done exp %0d got %0d", want.frame_done, m_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [10:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            pet_pkg::CFG_FRAME_WIDTH:    pw_width  = val[9:0];
            pet_pkg::CFG_FRAME_HEIGHT:   pw_height = val[9:0];
            pet_pkg::CFG_EDGE_THRESHOLD: pw_thresh = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pixel_q.size() > 0 || s_tvalid || edge_q.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic pixel_t rand_pixel(int mode);
        pixel_t p;
        case (mode)
            0: p = 24'h000000;
            1: p = 24'hFFFFFF;
            default: p = 24'($urandom);
        endcase
        return p;
    endfunction

    task automatic queue_frame(int w, int h, int style);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++) begin
                if (style == 1) pixel_q.push_back(((r + c) % 2) ? 24'hFFFFFF : 24'h000000);
                else if (style == 2) pixel_q.push_back(c < w / 2 ? 24'h000000 : 24'hFFFFFF);
                else pixel_q.push_back(rand_pixel($urandom_range(9)));
            end
    endtask

    initial begin
        int w, h;
        idle_pct = 0;
        cfg_valid = 1'b0;
        cfg_index = pet_pkg::CFG_FRAME_WIDTH;
        cfg_data = '0;
        pw_width = pet_pkg::RST_FRAME_WIDTH;
        pw_height = pet_pkg::RST_FRAME_HEIGHT;
        pw_thresh = pet_pkg::RST_EDGE_THRESHOLD;
        col_cnt = 0;
        row_cnt = 0;
        foreach (lines[i]) lines[i] = '0;
        foreach (win[i, j]) win[i][j] = '0;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: smallest frames, extremes, threshold ends
        cfg_write(pet_pkg::CFG_FRAME_WIDTH, 11'd3);
        cfg_write(pet_pkg::CFG_FRAME_HEIGHT, 11'd3);
        cfg_write(pet_pkg::CFG_EDGE_THRESHOLD, 11'd1082);
        queue_frame(3, 3, 1);
        queue_frame(3, 3, 2);
        wait_drained();
        cfg_write(pet_pkg::CFG_EDGE_THRESHOLD, 11'd0);
        queue_frame(3, 3, 2);
        wait_drained();

        // out-of-range sizes clamp; threshold above range
        cfg_write(pet_pkg::CFG_FRAME_WIDTH, 11'd1);
        cfg_write(pet_pkg::CFG_FRAME_HEIGHT, 11'd0);
        cfg_write(pet_pkg::CFG_EDGE_THRESHOLD, 11'd2047);
        queue_frame(3, 3, 0);
        wait_drained();

        // back-pressure: long receiver stall while input fills
        idle_pct = 29;
        cfg_write(pet_pkg::CFG_FRAME_WIDTH, 11'd8);
        cfg_write(pet_pkg::CFG_FRAME_HEIGHT, 11'd5);
        cfg_write(pet_pkg::CFG_EDGE_THRESHOLD, 11'd60);
        stall_req = 1'b1;
        queue_frame(8, 5, 0);
        wait_drained();

        // random frames, first stretch with no idling
        for (int f = 0; f < 8; f++) begin
            idle_pct = (f < 3) ? 0 : 29;
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            cfg_write(pet_pkg::CFG_FRAME_WIDTH, 11'(w));
            cfg_write(pet_pkg::CFG_FRAME_HEIGHT, 11'(h));
            cfg_write(pet_pkg::CFG_EDGE_THRESHOLD, 11'($urandom_range(0, 1100)));
            queue_frame(w, h, $urandom_range(3));
            wait_drained();
        end

        // one wide frame
        cfg_write(pet_pkg::CFG_FRAME_WIDTH, 11'd96);
        cfg_write(pet_pkg::CFG_FRAME_HEIGHT, 11'd3);
        cfg_write(pet_pkg::CFG_EDGE_THRESHOLD, 11'd170);
        queue_frame(96, 3, 0);
        wait_drained();

        if (fail_cnt == 0) $display("prewitt_edge_threshold test passed");
        else $display("prewitt_edge_threshold test failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("prewitt_edge_threshold test failed");
        $finish;
    end
endmodule

>>> prewitt_edge_threshold.f
rtl/pet_pkg.sv
rtl/pet_ctrl.sv
rtl/pet_dp.sv
rtl/prewitt_edge_threshold.sv
tb/prewitt_edge_threshold_tb.sv
